// ----- rtl/core/lcan_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcan_pkg
// Shared types, constants, saturation helper and microcode table for the
// calcium adaptive LIF neuron step.
// ----------------------------------------------------------------------------
package lcan_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 52;   // headroom for shifted products and sums
    localparam int MULT_W = 33;   // signed operand width of the shared multiplier
    localparam int PROD_W = 2 * MULT_W;
    localparam int FRAC_W = 15;
    localparam int SHORT_W = 16;
    localparam int STEP_W = 4;
    localparam int INDEX_W = 3;

    localparam logic [SHORT_W-1:0] REFRACT_STEP = 16'd10;
    localparam logic signed [DATA_W-1:0] CURRENT_OFFSET = 32'sd0;

    // configuration register indexes
    localparam logic [INDEX_W-1:0] CFG_FIRE_LEVEL     = 3'd0;
    localparam logic [INDEX_W-1:0] CFG_V_RESET        = 3'd1;
    localparam logic [INDEX_W-1:0] CFG_V_REST         = 3'd2;
    localparam logic [INDEX_W-1:0] CFG_MEM_RESIST     = 3'd3;
    localparam logic [INDEX_W-1:0] CFG_DECAY_MEMBRANE = 3'd4;
    localparam logic [INDEX_W-1:0] CFG_DECAY_CALCIUM  = 3'd5;
    localparam logic [INDEX_W-1:0] CFG_CALCIUM_INC    = 3'd6;
    localparam logic [INDEX_W-1:0] CFG_REFRACT_PERIOD = 3'd7;

    // multiplier operand selects
    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_CAL  = 2'd1;
    localparam logic [1:0] MUL_CUR  = 2'd2;
    localparam logic [1:0] MUL_DIFF = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_REFDEC = 3'd1;
    localparam logic [2:0] OP_CALDEC = 3'd2;
    localparam logic [2:0] OP_CUR    = 3'd3;
    localparam logic [2:0] OP_ALPHA  = 3'd4;
    localparam logic [2:0] OP_DIFF   = 3'd5;
    localparam logic [2:0] OP_VOLT   = 3'd6;
    localparam logic [2:0] OP_FIRE   = 3'd7;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_FIRE = 4'd8;

    typedef struct packed {
        logic [1:0]        mul_sel;
        logic [2:0]        op;
        logic              jmp_refr;   // jump to target while refractory
        logic [STEP_W-1:0] target;
        logic              done;
    } ctrl_word_t;

    typedef struct packed {
        logic refr_active;
    } dp_status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] fire_level;
        logic signed [DATA_W-1:0] v_reset;
        logic signed [DATA_W-1:0] v_rest;
        logic signed [DATA_W-1:0] mem_resist;
        logic [SHORT_W-1:0]       decay_membrane;
        logic [SHORT_W-1:0]       decay_calcium;
        logic signed [DATA_W-1:0] calcium_increment;
        logic [SHORT_W-1:0]       refractory_period;
    } neuron_cfg_t;

    localparam ctrl_word_t CW_IDLE = '{MUL_NONE, OP_NOP, 1'b0, '0, 1'b0};

    // clamp to the signed 32 bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic fits;
        fits = (x[WIDE_W-1:DATA_W-1] == '0) || (x[WIDE_W-1:DATA_W-1] == '1);
        if (fits) begin
            sat32 = x[DATA_W-1:0];
        end else if (x[WIDE_W-1]) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // microcode table: one control word per step
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = CW_IDLE;
        case (step)
            4'd0: begin cw.op = OP_REFDEC; cw.mul_sel = MUL_CAL; end
            4'd1: begin cw.op = OP_CALDEC; cw.jmp_refr = 1'b1; cw.target = STEP_FIRE; end
            4'd2: cw.op = OP_CUR;
            4'd3: cw.mul_sel = MUL_CUR;
            4'd4: cw.op = OP_ALPHA;
            4'd5: cw.op = OP_DIFF;
            4'd6: cw.mul_sel = MUL_DIFF;
            4'd7: cw.op = OP_VOLT;
            4'd8: cw.op = OP_FIRE;
            4'd9: cw.done = 1'b1;
            default: cw.done = 1'b1;
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lcan_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcan_seq
// Step counter over the microcode table with conditional jump and finish.
// ----------------------------------------------------------------------------
module lcan_seq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic                  out_blocked,
    input  wire lcan_pkg::dp_status_t  status,
    output lcan_pkg::ctrl_word_t       cw,
    output logic                       busy,
    output logic                       finish
);
    import lcan_pkg::*;

    logic              running_reg, running_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              hold;

    always_comb begin
        cw     = running_reg ? ucode_rom(step_reg) : CW_IDLE;
        hold   = cw.done && out_blocked;
        finish = running_reg && cw.done && !hold;
        busy   = running_reg;

        running_next = running_reg;
        step_next    = step_reg;
        if (start) begin
            running_next = 1'b1;
            step_next    = '0;
        end else if (running_reg && !hold) begin
            if (cw.done) begin
                running_next = 1'b0;
            end else if (cw.jmp_refr && status.refr_active) begin
                step_next = cw.target;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            running_reg <= running_next;
            step_reg    <= step_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lcan_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcan_dp
// Neuron state, one shared registered multiplier and the saturating adders.
// ----------------------------------------------------------------------------
module lcan_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                load,
    input  wire logic signed [lcan_pkg::DATA_W-1:0]  exc_in,
    input  wire logic signed [lcan_pkg::DATA_W-1:0]  inh_in,
    input  wire logic signed [lcan_pkg::DATA_W-1:0]  bias_in,
    input  wire lcan_pkg::neuron_cfg_t               cfg,
    input  wire lcan_pkg::ctrl_word_t                cw,
    output lcan_pkg::dp_status_t                     status,
    output logic                                     spike,
    output logic signed [lcan_pkg::DATA_W-1:0]       voltage
);
    import lcan_pkg::*;

    logic signed [DATA_W-1:0] exc_reg, inh_reg, bias_reg;
    logic signed [DATA_W-1:0] volt_reg, volt_next;
    logic signed [DATA_W-1:0] cal_reg, cal_next;
    logic [SHORT_W-1:0]       refr_reg, refr_next;
    logic                     spike_reg, spike_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [DATA_W-1:0] alpha_reg, alpha_next;
    logic signed [DATA_W:0]   diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MULT_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [WIDE_W-1:0] prod_sh;
    logic                     fire;

    // shared multiplier operands
    always_comb begin
        unique case (cw.mul_sel)
            MUL_CAL: begin
                mul_a = MULT_W'(cal_reg);
                mul_b = $signed(MULT_W'(cfg.decay_calcium));
            end
            MUL_CUR: begin
                mul_a = MULT_W'(cur_reg);
                mul_b = MULT_W'(cfg.mem_resist);
            end
            MUL_DIFF: begin
                mul_a = diff_reg;
                mul_b = $signed(MULT_W'(cfg.decay_membrane));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cw.mul_sel != MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // floor shift; the result fits well inside the wide range
    assign prod_shr = prod_reg >>> FRAC_W;
    assign prod_sh  = prod_shr[WIDE_W-1:0];

    assign fire = (refr_reg == '0) && (volt_reg >= cfg.fire_level);

    always_comb begin
        volt_next  = volt_reg;
        cal_next   = cal_reg;
        refr_next  = refr_reg;
        spike_next = spike_reg;
        cur_next   = cur_reg;
        alpha_next = alpha_reg;
        diff_next  = diff_reg;
        unique case (cw.op)
            OP_REFDEC: begin
                refr_next  = (refr_reg > REFRACT_STEP) ? refr_reg - REFRACT_STEP : '0;
                spike_next = 1'b0;
            end
            OP_CALDEC: cal_next = sat32(prod_sh);
            OP_CUR: begin
                cur_next = sat32(WIDE_W'(exc_reg) - WIDE_W'(inh_reg) - WIDE_W'(cal_reg)
                                 + WIDE_W'(bias_reg) + WIDE_W'(CURRENT_OFFSET));
            end
            OP_ALPHA: alpha_next = sat32(prod_sh + WIDE_W'(cfg.v_rest));
            OP_DIFF:  diff_next  = (DATA_W+1)'(alpha_reg) - (DATA_W+1)'(volt_reg);
            OP_VOLT:  volt_next  = sat32(WIDE_W'(alpha_reg) - prod_sh);
            OP_FIRE: begin
                if (fire) begin
                    spike_next = 1'b1;
                    volt_next  = cfg.v_reset;
                    refr_next  = cfg.refractory_period;
                    cal_next   = sat32(WIDE_W'(cal_reg) + WIDE_W'(cfg.calcium_increment));
                end
            end
            default: ;
        endcase
    end

    // neuron state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_reg  <= '0;
            cal_reg   <= '0;
            refr_reg  <= '0;
            spike_reg <= 1'b0;
        end else begin
            volt_reg  <= volt_next;
            cal_reg   <= cal_next;
            refr_reg  <= refr_next;
            spike_reg <= spike_next;
        end
    end

    // working values and captured inputs
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        alpha_reg <= alpha_next;
        diff_reg  <= diff_next;
        if (load) begin
            exc_reg  <= exc_in;
            inh_reg  <= inh_in;
            bias_reg <= bias_in;
        end
    end

    assign status.refr_active = (refr_reg != '0);
    assign spike   = spike_reg;
    assign voltage = volt_reg;

endmodule
`default_nettype wire

// ----- rtl/core/lif_calcium_adaptive_neuron_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lif_calcium_adaptive_neuron_step
// One time step of a leaky integrate-and-fire neuron with calcium adaptation,
// run by a small microcoded sequencer over a shared-multiplier datapath.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                       Content
//  s_        in   s_tvalid/s_tready/s_tdata     excitatory, inhibitory, bias
//  m_        out  m_tvalid/m_tready/m_tdata     membrane voltage, spike flag
//  cfg_      in   cfg_valid/cfg_ready           register index and write data
//
//  After its transfer an item runs every microcode step, or jumps to the
//  fire step while refractory; the input is ready again the cycle after it
//  finishes, so items do not overlap. The pace is set by the single 33x33
//  multiplier, which serves three dependent products in turn.
//  Reset clears the neuron state, the registers and the result channel; both
//  input channels hold ready low while reset is asserted.
//  A result waiting on m_tready does not block the next input transfer; the
//  sequencer holds on its last step until the output register frees up.
// ----------------------------------------------------------------------------
module lif_calcium_adaptive_neuron_step (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] excitatory_current, [63:32] inhibitory_current, [95:64] bias_current
    input  wire logic [3*lcan_pkg::DATA_W-1:0]  s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] membrane_voltage
    output logic [lcan_pkg::DATA_W-1:0]         m_tdata,
    // [0] spike
    output logic                                m_tuser,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lcan_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [lcan_pkg::DATA_W-1:0]    cfg_data
);
    import lcan_pkg::*;

    neuron_cfg_t              cfg_reg, cfg_next;
    ctrl_word_t               cw;
    dp_status_t               status;
    logic                     busy, finish, start, out_blocked;
    logic                     spike;
    logic signed [DATA_W-1:0] voltage;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]        m_tdata_reg;
    logic                     m_tuser_reg;

    // take one item whenever the sequencer is free and out of reset
    assign s_tready    = aresetn && !busy;
    assign start       = s_tvalid && s_tready;
    assign out_blocked = m_tvalid_reg && !m_tready;

    // configuration registers, writable whenever out of reset
    assign cfg_ready = aresetn;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FIRE_LEVEL:     cfg_next.fire_level        = cfg_data;
                CFG_V_RESET:        cfg_next.v_reset           = cfg_data;
                CFG_V_REST:         cfg_next.v_rest            = cfg_data;
                CFG_MEM_RESIST:     cfg_next.mem_resist        = cfg_data;
                CFG_DECAY_MEMBRANE: cfg_next.decay_membrane    = cfg_data[SHORT_W-1:0];
                CFG_DECAY_CALCIUM:  cfg_next.decay_calcium     = cfg_data[SHORT_W-1:0];
                CFG_CALCIUM_INC:    cfg_next.calcium_increment = cfg_data;
                CFG_REFRACT_PERIOD: cfg_next.refractory_period = cfg_data[SHORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcan_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .out_blocked (out_blocked),
        .status      (status),
        .cw          (cw),
        .busy        (busy),
        .finish      (finish)
    );

    lcan_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (start),
        .exc_in   (s_tdata[DATA_W-1:0]),
        .inh_in   (s_tdata[2*DATA_W-1:DATA_W]),
        .bias_in  (s_tdata[3*DATA_W-1:2*DATA_W]),
        .cfg      (cfg_reg),
        .cw       (cw),
        .status   (status),
        .spike    (spike),
        .voltage  (voltage)
    );

    // output register: load on finish, drop once transferred
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= voltage;
            m_tuser_reg <= spike;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a finished step never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten while waiting");

    // a transfer starts the sequencer on the next cycle
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (busy && !finish))
        else $error("sequencer did not start");

    // a new result appears only after a finished step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(finish))
        else $error("result valid without a finished step");

    // a spike result carries the reset voltage
    a_spike_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && spike) |-> (voltage == cfg_reg.v_reset || $past(cfg_valid)
                               || $past(cfg_valid, 2)))
        else $error("spike without voltage reset");

endmodule
`default_nettype wire
